>>> sv/caei_pkg.sv
// shared types and constants for the current average and energy integrator
package caei_pkg;

  // fixed field widths
  localparam int ADC_BITS       = 10;
  localparam int TIME_W         = 32;
  localparam int CUR_W          = 15;
  localparam int ADDED_W        = 22;
  localparam int ENERGY_W       = 32;
  localparam int CFG_W          = 4;

  // default and reset values
  localparam int MAX_AVERAGE_LOG2_DEF = 12;
  localparam logic [CFG_W-1:0] AVERAGE_LOG2_RESET = 4'd4;

  // offset removal and clamp
  localparam int OFFSET    = 512;
  localparam int CLAMP_LIM = 189;
  localparam int CLAMP_LO  = OFFSET - CLAMP_LIM;
  localparam int CLAMP_HI  = OFFSET + CLAMP_LIM;
  localparam int U_W       = 9;

  // linear map: q = floor(u * 5000 / 189) as (u * MAP_RECIP) >> MAP_SHIFT
  // exact over u in 0..378
  localparam int OUT_LIM   = 5000;
  localparam int Q_W       = 14;
  localparam int MAP_SHIFT = 24;
  localparam int MAP_RW    = 29;
  localparam logic [MAP_RW-1:0] MAP_RECIP = 29'd443841694;

  // times 4, keep 94 percent: floor(v * 94 / 25) as (v * KEEP_RECIP) >> KEEP_SHIFT
  // exact over v in 0..5000
  localparam int V_W        = 13;
  localparam int KEEP_SHIFT = 28;
  localparam int KEEP_RW    = 30;
  localparam logic [KEEP_RW-1:0] KEEP_RECIP = 30'd1009317315;

  localparam int ENERGY_SHIFT = 10;

  // report queue
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic [ADC_BITS-1:0] adc_sample;
    logic [TIME_W-1:0]   time_ms;
  } in_item_t;

  typedef struct packed {
    logic [CUR_W-1:0]           current_scaled;
    logic [TIME_W-1:0]          delta_ms;
    logic [ADDED_W-1:0]         energy_added;
    logic signed [ENERGY_W-1:0] energy_total;
  } out_item_t;

endpackage

>>> sv/caei_front.sv
// sample accumulator: sums samples and hands completed averages to the report queue
module caei_front #(
  parameter int MAX_AVERAGE_LOG2 = caei_pkg::MAX_AVERAGE_LOG2_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  caei_pkg::in_item_t                    in_data,
  input  logic [caei_pkg::CFG_W-1:0]            average_log2,
  output logic                                  push_valid,
  input  logic                                  push_ready,
  output logic [caei_pkg::ADC_BITS+MAX_AVERAGE_LOG2-1:0] push_avg,
  output logic [caei_pkg::TIME_W-1:0]           push_time
);

  localparam int SUM_W  = caei_pkg::ADC_BITS + MAX_AVERAGE_LOG2;
  localparam int CNT_W  = MAX_AVERAGE_LOG2 + 1;
  localparam int LOG2_W = $clog2(MAX_AVERAGE_LOG2 + 1);

  logic [SUM_W-1:0]  sample_sum;
  logic [CNT_W-1:0]  sample_count;
  logic [SUM_W-1:0]  sum_next;
  logic [CNT_W-1:0]  count_next;
  logic [CNT_W-1:0]  target;
  logic [LOG2_W-1:0] eff_log2;
  logic              report;
  logic              accept;

  // register value above the supported maximum saturates
  assign eff_log2 = ({28'd0, average_log2} > 32'(MAX_AVERAGE_LOG2)) ?
                    LOG2_W'(MAX_AVERAGE_LOG2) : LOG2_W'(average_log2);

  assign sum_next   = sample_sum + SUM_W'(in_data.adc_sample);
  assign count_next = sample_count + CNT_W'(1);
  assign target     = CNT_W'(1) << eff_log2;
  assign report     = (count_next >= target);

  assign in_ready   = push_ready;
  assign accept     = in_valid && in_ready;
  assign push_valid = in_valid && report;
  assign push_avg   = sum_next >> eff_log2;
  assign push_time  = in_data.time_ms;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_sum   <= '0;
      sample_count <= '0;
    end else if (accept) begin
      if (report) begin
        sample_sum   <= '0;
        sample_count <= '0;
      end else begin
        sample_sum   <= sum_next;
        sample_count <= count_next;
      end
    end
  end

endmodule

>>> sv/caei_queue.sv
// two-entry report queue between the accumulator and the report arithmetic
module caei_queue #(
  parameter int AVG_W = caei_pkg::ADC_BITS + caei_pkg::MAX_AVERAGE_LOG2_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push_valid,
  output logic                          push_ready,
  input  logic [AVG_W-1:0]              push_avg,
  input  logic [caei_pkg::TIME_W-1:0]   push_time,
  output logic                          pop_valid,
  input  logic                          pop_ready,
  output logic [AVG_W-1:0]              pop_avg,
  output logic [caei_pkg::TIME_W-1:0]   pop_time
);

  localparam int CNT_W = caei_pkg::QPTR_W + 1;

  logic [AVG_W-1:0]            avg_mem  [caei_pkg::QUEUE_DEPTH];
  logic [caei_pkg::TIME_W-1:0] time_mem [caei_pkg::QUEUE_DEPTH];
  logic [caei_pkg::QPTR_W-1:0] wr_ptr;
  logic [caei_pkg::QPTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0]            fill;
  logic                        do_push;
  logic                        do_pop;

  assign push_ready = (fill != CNT_W'(caei_pkg::QUEUE_DEPTH));
  assign pop_valid  = (fill != '0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign pop_avg    = avg_mem[rd_ptr];
  assign pop_time   = time_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      avg_mem[wr_ptr]  <= push_avg;
      time_mem[wr_ptr] <= push_time;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + caei_pkg::QPTR_W'(1);
      if (do_pop)  rd_ptr <= rd_ptr + caei_pkg::QPTR_W'(1);
      unique case ({do_push, do_pop})
        2'b10:   fill <= fill + CNT_W'(1);
        2'b01:   fill <= fill - CNT_W'(1);
        default: fill <= fill;
      endcase
    end
  end

endmodule

>>> sv/caei_back.sv
// report sequencer: scales the average, integrates energy, holds the result item
module caei_back #(
  parameter int AVG_W = caei_pkg::ADC_BITS + caei_pkg::MAX_AVERAGE_LOG2_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          pop_valid,
  output logic                          pop_ready,
  input  logic [AVG_W-1:0]              pop_avg,
  input  logic [caei_pkg::TIME_W-1:0]   pop_time,
  output logic                          out_valid,
  input  logic                          out_ready,
  output caei_pkg::out_item_t           out_data
);

  localparam int MAP_PW  = caei_pkg::U_W + caei_pkg::MAP_RW;
  localparam int KEEP_PW = caei_pkg::V_W + caei_pkg::KEEP_RW;
  localparam int TW      = caei_pkg::TIME_W;

  typedef enum logic [1:0] {S_MAP, S_SCALE, S_MUL, S_OUT} state_t;

  state_t                       state;
  logic [caei_pkg::Q_W-1:0]     q_map;
  logic [caei_pkg::CUR_W-1:0]   cur;
  logic [TW-1:0]                delta;
  logic [TW-1:0]                prod;
  logic [TW-1:0]                last_report_time;
  logic [caei_pkg::ENERGY_W-1:0] energy_accumulator;

  logic [caei_pkg::U_W-1:0]     u;
  logic [MAP_PW-1:0]            map_prod;
  logic [caei_pkg::V_W-1:0]     v;
  logic [KEEP_PW-1:0]           keep_prod;
  logic                         positive;
  logic [caei_pkg::ADDED_W-1:0] added;
  logic [caei_pkg::ENERGY_W-1:0] energy_next;
  logic                         out_free;
  logic                         out_load;

  // offset removal and clamp, shifted so the clamped value starts at zero
  always_comb begin
    if (pop_avg >= AVG_W'(caei_pkg::CLAMP_HI)) begin
      u = caei_pkg::U_W'(2 * caei_pkg::CLAMP_LIM);
    end else if (pop_avg <= AVG_W'(caei_pkg::CLAMP_LO)) begin
      u = '0;
    end else begin
      u = caei_pkg::U_W'(pop_avg - AVG_W'(caei_pkg::CLAMP_LO));
    end
  end

  assign map_prod  = MAP_PW'(u) * MAP_PW'(caei_pkg::MAP_RECIP);
  assign positive  = (q_map > caei_pkg::Q_W'(caei_pkg::OUT_LIM));
  assign v         = caei_pkg::V_W'(q_map - caei_pkg::Q_W'(caei_pkg::OUT_LIM));
  assign keep_prod = KEEP_PW'(v) * KEEP_PW'(caei_pkg::KEEP_RECIP);
  assign added       = prod[caei_pkg::ENERGY_SHIFT +: caei_pkg::ADDED_W];
  assign energy_next = energy_accumulator + caei_pkg::ENERGY_W'(added);
  assign out_free    = !out_valid || out_ready;
  assign out_load    = (state == S_OUT) && out_free;
  assign pop_ready   = (state == S_MAP);

  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= S_MAP;
      out_valid          <= 1'b0;
      last_report_time   <= '0;
      energy_accumulator <= '0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_MAP: begin
          if (pop_valid) begin
            q_map            <= map_prod[caei_pkg::MAP_SHIFT +: caei_pkg::Q_W];
            delta            <= pop_time - last_report_time;
            last_report_time <= pop_time;
            state            <= S_SCALE;
          end
        end
        S_SCALE: begin
          // non-positive scaled current reads as zero
          cur   <= positive ? keep_prod[caei_pkg::KEEP_SHIFT +: caei_pkg::CUR_W] : '0;
          state <= S_MUL;
        end
        S_MUL: begin
          prod  <= TW'(TW'(cur) * delta);
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            energy_accumulator      <= energy_next;
            out_data.current_scaled <= cur;
            out_data.delta_ms       <= delta;
            out_data.energy_added   <= added;
            out_data.energy_total   <= signed'(energy_next);
            state                   <= S_MAP;
          end
        end
        default: state <= S_MAP;
      endcase
    end
  end

endmodule

>>> sv/current_average_energy_integrator.sv
// top level of the current average and energy integrator
//
//  channel   direction  handshake                 payload
//  in        input      in_valid / in_ready        in_data   (adc_sample, time_ms)
//  out       output     out_valid / out_ready      out_data  (current_scaled, delta_ms,
//                                                             energy_added, energy_total)
//  cfg       input      cfg_write_en               cfg_write_data (average_log2)
//
// a sample item is taken whenever the report queue has room
// an item that completes an average goes through the report sequencer steps in order
//   (map multiply, keep-94% multiply, current-times-delta multiply, accumulate)
// a new report item waits until the last has left; the two-entry queue absorbs bursts
// synchronous reset clears sums, counts, report time, energy total and the queue;
//   average_log2 comes out of reset at 4
// a stalled result holds in the output register; samples keep coming in until
//   the queue fills, then in_ready drops
module current_average_energy_integrator #(
  parameter int MAX_AVERAGE_LOG2 = caei_pkg::MAX_AVERAGE_LOG2_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  caei_pkg::in_item_t            in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output caei_pkg::out_item_t           out_data,
  input  logic                          cfg_write_en,
  input  logic [caei_pkg::CFG_W-1:0]    cfg_write_data
);

  // sum of up to 2^MAX_AVERAGE_LOG2 samples, also the widest average
  localparam int AVG_W = caei_pkg::ADC_BITS + MAX_AVERAGE_LOG2;

  // configuration register
  logic [caei_pkg::CFG_W-1:0] average_log2;

  // front to queue
  logic                        push_valid;
  logic                        push_ready;
  logic [AVG_W-1:0]            push_avg;
  logic [caei_pkg::TIME_W-1:0] push_time;

  // queue to back
  logic                        pop_valid;
  logic                        pop_ready;
  logic [AVG_W-1:0]            pop_avg;
  logic [caei_pkg::TIME_W-1:0] pop_time;

  // to be written only while idle (the block does not enforce it), so no interlock with items in flight
  always_ff @(posedge clk) begin
    if (rst) begin
      average_log2 <= caei_pkg::AVERAGE_LOG2_RESET;
    end else if (cfg_write_en) begin
      average_log2 <= cfg_write_data;
    end
  end

  // accumulate samples, decide when a report is due
  caei_front #(
    .MAX_AVERAGE_LOG2 (MAX_AVERAGE_LOG2)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data      (in_data),
    .average_log2 (average_log2),
    .push_valid   (push_valid),
    .push_ready   (push_ready),
    .push_avg     (push_avg),
    .push_time    (push_time)
  );

  // decouples sample intake from report arithmetic
  caei_queue #(
    .AVG_W (AVG_W)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_avg   (push_avg),
    .push_time  (push_time),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_avg    (pop_avg),
    .pop_time   (pop_time)
  );

  // scale, integrate energy, drive the result item
  caei_back #(
    .AVG_W (AVG_W)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_avg   (pop_avg),
    .pop_time  (pop_time),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

>>> sv/caei_checker.sv
// port-level checks for the current average and energy integrator, bound to the top level
module caei_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_ready,
  input caei_pkg::in_item_t         in_data,
  input logic                       out_valid,
  input logic                       out_ready,
  input caei_pkg::out_item_t        out_data,
  input logic                       cfg_write_en,
  input logic [caei_pkg::CFG_W-1:0] cfg_write_data
);

  // a waiting result item holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result item changed while stalled");

  // nothing to show right after reset
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

  // added energy follows from current and elapsed time
  a_added: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.energy_added ==
      caei_pkg::ADDED_W'((32'(out_data.current_scaled) * out_data.delta_ms)
                         >> caei_pkg::ENERGY_SHIFT))
    else $error("energy_added inconsistent with current and delta");

  // scaled current never exceeds full scale
  a_cur_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.current_scaled <= caei_pkg::CUR_W'(18800))
    else $error("current_scaled above full scale");

  // accepted items and register writes carry known values
  a_known_inputs: assert property (@(posedge clk) disable iff (rst)
    cfg_write_en || (in_valid && in_ready) |-> !$isunknown({in_data, cfg_write_data}))
    else $error("unknown value on an accepted item or register write");

endmodule

bind current_average_energy_integrator caei_checker u_caei_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .in_data        (in_data),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_data       (out_data),
  .cfg_write_en   (cfg_write_en),
  .cfg_write_data (cfg_write_data)
);
